// ----- design/suhd_pkg.sv -----
// ----------------------------------------------------------------------------
// suhd_pkg
// Shared types and constants for the Super I/O configuration window and the
// small 16550-style UART that answers the handshake request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package suhd_pkg;

  // Access kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Access windows.
  localparam logic [1:0] WIN_INDEX = 2'd0;
  localparam logic [1:0] WIN_DATA  = 2'd1;
  localparam logic [1:0] WIN_UART  = 2'd2;

  // UART register offsets.
  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;

  // Index port keys and handshake bytes.
  localparam logic [7:0] KEY_UNLOCK = 8'h87;
  localparam logic [7:0] KEY_LOCK   = 8'hAA;
  localparam logic [7:0] HS_REQUEST = 8'hA5;
  localparam logic [7:0] HS_ACK     = 8'hA0;

  // Configuration register indexes.
  localparam logic [7:0] IDX_IDENT   = 8'h20;
  localparam logic [7:0] IDX_REV     = 8'h21;
  localparam logic [7:0] IDX_LDN     = 8'h07;
  localparam logic [7:0] IDX_ACTIVE  = 8'h30;
  localparam logic [7:0] IDX_BASE_HI = 8'h60;
  localparam logic [7:0] IDX_BASE_LO = 8'h61;
  localparam logic [7:0] IDX_IRQ     = 8'h70;

  // Read values.
  localparam logic [7:0] PORT_IDLE   = 8'hFF;
  localparam logic [7:0] ACTIVE_ON   = 8'h01;
  localparam logic [7:0] DLL_VALUE   = 8'h01;
  localparam logic [7:0] IIR_RXAVAIL = 8'h04;
  localparam logic [7:0] IIR_NONE    = 8'h01;
  localparam logic [7:0] LSR_TXEMPTY = 8'h60;
  localparam logic [7:0] DLAB_MASK   = 8'h80;
  localparam logic [7:0] IER_RXINT   = 8'h01;

  localparam logic [1:0] UNLOCK_MAX = 2'd2;
  localparam logic [1:0] REPLY_LEN  = 2'd3;

  // Host register map.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] CFG_CHIP_IDENT    = 3'd0;
  localparam logic [2:0] CFG_CHIP_REVISION = 3'd1;
  localparam logic [2:0] CFG_UART_BASE     = 3'd2;
  localparam logic [2:0] CFG_IRQ_NUMBER    = 3'd3;
  localparam logic [2:0] CFG_VERSION_HIGH  = 3'd4;
  localparam logic [2:0] CFG_VERSION_LOW   = 3'd5;

  localparam logic [7:0]  RST_CHIP_IDENT    = 8'h87;
  localparam logic [7:0]  RST_CHIP_REVISION = 8'h12;
  localparam logic [15:0] RST_UART_BASE     = 16'h0240;
  localparam logic [3:0]  RST_IRQ_NUMBER    = 4'd5;
  localparam logic [7:0]  RST_VERSION_HIGH  = 8'h02;
  localparam logic [7:0]  RST_VERSION_LOW   = 8'h01;

  typedef struct packed {
    logic       req_type;
    logic [1:0] window;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
  } suhd_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
  } suhd_result_t;

  typedef struct packed {
    logic [7:0]  chip_ident;
    logic [7:0]  chip_revision;
    logic [15:0] uart_base_report;
    logic [3:0]  irq_number;
    logic [7:0]  version_high;
    logic [7:0]  version_low;
  } suhd_cfg_t;

  typedef struct packed {
    logic       config_locked;
    logic [1:0] unlock_seen;
    logic       data_ready;
    logic [1:0] reply_pos;
    logic [1:0] reply_count;
    logic       irq_level;
  } suhd_status_t;

endpackage

`default_nettype wire

// ----- design/suhd_if.sv -----
// ----------------------------------------------------------------------------
// suhd_if
// Valid/ready channels for bus access items and their read results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface suhd_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [1:0] window;
  logic [2:0] reg_offset;
  logic [7:0] write_data;

  modport source (output valid, req_type, window, reg_offset, write_data, input ready);
  modport sink   (input valid, req_type, window, reg_offset, write_data, output ready);
endinterface

interface suhd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_line;

  modport source (output valid, read_data, irq_line, input ready);
  modport sink   (input valid, read_data, irq_line, output ready);
endinterface

`default_nettype wire

// ----- design/superio_uart_handshake_device.sv -----
// An accepted item waits in the input register until the result register is
// free or being emptied. One item per cycle unless responses stall; the input
// register refills in the cycle its item moves to the result register, which
// holds a stalled result.
// Reset: asynchronous, active low; configuration is locked, all UART state is
// cleared and the host registers return to their documented defaults.
// ----------------------------------------------------------------------------
// superio_uart_handshake_device
// Super I/O configuration port pair with a minimal 16550 UART subset that
// answers a three-byte handshake, behind valid/ready channels and an APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module superio_uart_handshake_device import suhd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  suhd_req_if.sink              req_i,
  suhd_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  suhd_cfg_t    cfg_q;
  logic         cfg_wr;
  logic [2:0]   cfg_sel;

  logic         in_valid_q;
  suhd_item_t   item_q;
  logic         out_valid_q;
  suhd_result_t out_q;
  logic         adv;
  suhd_result_t result;
  suhd_status_t status;

  // Host register port.
  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chip_ident       <= RST_CHIP_IDENT;
      cfg_q.chip_revision    <= RST_CHIP_REVISION;
      cfg_q.uart_base_report <= RST_UART_BASE;
      cfg_q.irq_number       <= RST_IRQ_NUMBER;
      cfg_q.version_high     <= RST_VERSION_HIGH;
      cfg_q.version_low      <= RST_VERSION_LOW;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        CFG_CHIP_IDENT:    cfg_q.chip_ident       <= pwdata[7:0];
        CFG_CHIP_REVISION: cfg_q.chip_revision    <= pwdata[7:0];
        CFG_UART_BASE:     cfg_q.uart_base_report <= pwdata[15:0];
        CFG_IRQ_NUMBER:    cfg_q.irq_number       <= pwdata[3:0];
        CFG_VERSION_HIGH:  cfg_q.version_high     <= pwdata[7:0];
        CFG_VERSION_LOW:   cfg_q.version_low      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      CFG_CHIP_IDENT:    prdata = {24'h0, cfg_q.chip_ident};
      CFG_CHIP_REVISION: prdata = {24'h0, cfg_q.chip_revision};
      CFG_UART_BASE:     prdata = {16'h0, cfg_q.uart_base_report};
      CFG_IRQ_NUMBER:    prdata = {28'h0, cfg_q.irq_number};
      CFG_VERSION_HIGH:  prdata = {24'h0, cfg_q.version_high};
      CFG_VERSION_LOW:   prdata = {24'h0, cfg_q.version_low};
      default:           prdata = 32'h0;
    endcase
  end

  // The held item is decoded and retired whenever the result register is free
  // or being emptied in the same cycle.
  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.req_type   <= req_i.req_type;
      item_q.window     <= req_i.window;
      item_q.reg_offset <= req_i.reg_offset;
      item_q.write_data <= req_i.write_data;
    end
  end

  suhd_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= result;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_q.read_data;
  assign rsp_o.irq_line  = out_q.irq_line;

`ifndef NO_ASSERTIONS
  // The interrupt is only raised together with a queued reply and is dropped
  // with it.
  a_irq_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.irq_level |-> status.data_ready)
    else $error("interrupt level set without a pending reply");

  a_reply_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.reply_pos <= status.reply_count)
    else $error("reply position ran past the reply length");

  a_unlock_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.unlock_seen <= UNLOCK_MAX)
    else $error("unlock counter passed its saturation value");

  a_retire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("retired item did not reach the result register");
`endif

endmodule

`default_nettype wire

// ----- design/suhd_regs.sv -----
// ----------------------------------------------------------------------------
// suhd_regs
// Super I/O and UART register state with the decode of one access item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module suhd_regs import suhd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  suhd_item_t   item_i,
  input  suhd_cfg_t    cfg_i,
  output suhd_result_t result_o,
  output suhd_status_t status_o
);

  logic [7:0] idx_q, idx_d;
  logic [7:0] ldn_q, ldn_d;
  logic       locked_q, locked_d;
  logic [1:0] unlock_q, unlock_d;
  logic [7:0] lcr_q, lcr_d;
  logic [7:0] ier_q, ier_d;
  logic [7:0] mcr_q, mcr_d;
  logic       dr_q, dr_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] cnt_q, cnt_d;
  logic       irq_q, irq_d;
  logic [7:0] rd;
  logic       dlab;

  always_comb begin
    idx_d    = idx_q;
    ldn_d    = ldn_q;
    locked_d = locked_q;
    unlock_d = unlock_q;
    lcr_d    = lcr_q;
    ier_d    = ier_q;
    mcr_d    = mcr_q;
    dr_d     = dr_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    irq_d    = irq_q;
    rd       = 8'h00;
    dlab     = (lcr_q & DLAB_MASK) != 8'h00;

    if (item_i.req_type == REQ_WRITE) begin
      unique case (item_i.window)
        WIN_INDEX: begin
          if (item_i.write_data == KEY_UNLOCK) begin
            if (unlock_q < UNLOCK_MAX) unlock_d = unlock_q + 2'd1;
            if (unlock_d >= UNLOCK_MAX) locked_d = 1'b0;
          end else if (item_i.write_data == KEY_LOCK) begin
            locked_d = 1'b1;
            unlock_d = 2'd0;
          end else begin
            unlock_d = 2'd0;
            if (!locked_q) idx_d = item_i.write_data;
          end
        end
        WIN_DATA: begin
          if (!locked_q && idx_q == IDX_LDN) ldn_d = item_i.write_data;
        end
        WIN_UART: begin
          unique case (item_i.reg_offset)
            OFF_RBR: begin
              if (!dlab && item_i.write_data == HS_REQUEST) begin
                cnt_d = REPLY_LEN;
                pos_d = 2'd0;
                dr_d  = 1'b1;
                if ((ier_q & IER_RXINT) != 8'h00) irq_d = 1'b1;
              end
            end
            OFF_IER: if (!dlab) ier_d = item_i.write_data;
            OFF_LCR: lcr_d = item_i.write_data;
            OFF_MCR: mcr_d = item_i.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end else begin
      unique case (item_i.window)
        WIN_INDEX: rd = PORT_IDLE;
        WIN_DATA: begin
          if (locked_q) begin
            rd = PORT_IDLE;
          end else begin
            unique case (idx_q)
              IDX_IDENT:   rd = cfg_i.chip_ident;
              IDX_REV:     rd = cfg_i.chip_revision;
              IDX_LDN:     rd = ldn_q;
              IDX_ACTIVE:  rd = ACTIVE_ON;
              IDX_BASE_HI: rd = cfg_i.uart_base_report[15:8];
              IDX_BASE_LO: rd = cfg_i.uart_base_report[7:0];
              IDX_IRQ:     rd = {4'h0, cfg_i.irq_number};
              default:     rd = 8'h00;
            endcase
          end
        end
        WIN_UART: begin
          unique case (item_i.reg_offset)
            OFF_RBR: begin
              if (dlab) begin
                rd = DLL_VALUE;
              end else if (pos_q < cnt_q) begin
                unique case (pos_q)
                  2'd0:    rd = HS_ACK;
                  2'd1:    rd = cfg_i.version_high;
                  default: rd = cfg_i.version_low;
                endcase
                // The position stays below three here, so the increment fits.
                pos_d = pos_q + 2'd1;
                if (pos_d >= cnt_q) begin
                  dr_d  = 1'b0;
                  irq_d = 1'b0;
                end
              end
            end
            OFF_IER: rd = dlab ? 8'h00 : ier_q;
            OFF_IIR: rd = dr_q ? IIR_RXAVAIL : IIR_NONE;
            OFF_LCR: rd = lcr_q;
            OFF_MCR: rd = mcr_q;
            OFF_LSR: rd = {7'h00, dr_q} | LSR_TXEMPTY;
            default: rd = 8'h00;
          endcase
        end
        default: rd = PORT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 8'h00;
      ldn_q    <= 8'h00;
      locked_q <= 1'b1;
      unlock_q <= 2'd0;
      lcr_q    <= 8'h00;
      ier_q    <= 8'h00;
      mcr_q    <= 8'h00;
      dr_q     <= 1'b0;
      pos_q    <= 2'd0;
      cnt_q    <= 2'd0;
      irq_q    <= 1'b0;
    end else if (en_i) begin
      idx_q    <= idx_d;
      ldn_q    <= ldn_d;
      locked_q <= locked_d;
      unlock_q <= unlock_d;
      lcr_q    <= lcr_d;
      ier_q    <= ier_d;
      mcr_q    <= mcr_d;
      dr_q     <= dr_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      irq_q    <= irq_d;
    end
  end

  assign result_o.read_data = rd;
  assign result_o.irq_line  = irq_d;

  assign status_o.config_locked = locked_q;
  assign status_o.unlock_seen   = unlock_q;
  assign status_o.data_ready    = dr_q;
  assign status_o.reply_pos     = pos_q;
  assign status_o.reply_count   = cnt_q;
  assign status_o.irq_level     = irq_q;

endmodule

`default_nettype wire

// ----- dv/superio_uart_handshake_device_test.sv -----
// ----------------------------------------------------------------------------
// superio_uart_handshake_device_test
// Drives bus accesses into the Super I/O and UART windows through the request
// channel, predicts every read byte and interrupt level in a local copy of the
// device state, and checks each response in order. The host registers are
// reloaded between phases while the device is idle, and both channels idle at
// random except in the all-ones phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module superio_uart_handshake_device_test;
  import suhd_pkg::*;

  localparam logic [1:0] WIN_NONE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  suhd_req_if req_if ();
  suhd_rsp_if rsp_if ();

  superio_uart_handshake_device dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Shadow of the device: host registers and access state.
  suhd_cfg_t  host_regs;
  logic [7:0] shadow_index;
  logic [7:0] sio_ldn;
  logic       shadow_locked;
  logic [1:0] sio_unlock_cnt;
  logic [7:0] shadow_lcr;
  logic [7:0] shadow_ier;
  logic [7:0] shadow_mcr;
  logic       uart_rx_ready;
  logic [1:0] reply_idx;
  logic [1:0] reply_len;
  logic       irq_q;

  suhd_item_t   pending_accesses[$];
  suhd_result_t predicted_reads[$];
  suhd_item_t   drv_item;

  bit hold_tx = 1'b0;
  bit gaps_en = 1'b1;

  int unsigned queued_items = 0;
  int unsigned sent_items = 0;
  int unsigned checked_results = 0;
  int unsigned irq_results = 0;
  int unsigned settings_loaded = 0;
  int unsigned fail_count = 0;

  task automatic predict_access(input suhd_item_t it, output suhd_result_t res);
    logic [7:0] rd;
    logic       dlab;
    rd = 8'h00;
    dlab = (shadow_lcr & DLAB_MASK) != 8'h00;
    if (it.req_type == REQ_WRITE) begin
      case (it.window)
        WIN_INDEX: begin
          if (it.write_data == KEY_UNLOCK) begin
            if (sio_unlock_cnt < UNLOCK_MAX) sio_unlock_cnt = sio_unlock_cnt + 2'd1;
            if (sio_unlock_cnt >= UNLOCK_MAX) shadow_locked = 1'b0;
          end else if (it.write_data == KEY_LOCK) begin
            shadow_locked = 1'b1;
            sio_unlock_cnt = 2'd0;
          end else begin
            sio_unlock_cnt = 2'd0;
            if (!shadow_locked) shadow_index = it.write_data;
          end
        end
        WIN_DATA: begin
          if (!shadow_locked && shadow_index == IDX_LDN) sio_ldn = it.write_data;
        end
        WIN_UART: begin
          case (it.reg_offset)
            OFF_RBR: begin
              if (!dlab && it.write_data == HS_REQUEST) begin
                reply_len = REPLY_LEN;
                reply_idx = 2'd0;
                uart_rx_ready = 1'b1;
                if ((shadow_ier & IER_RXINT) != 8'h00) irq_q = 1'b1;
              end
            end
            OFF_IER: if (!dlab) shadow_ier = it.write_data;
            OFF_LCR: shadow_lcr = it.write_data;
            OFF_MCR: shadow_mcr = it.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end else begin
      case (it.window)
        WIN_INDEX: rd = PORT_IDLE;
        WIN_DATA: begin
          if (shadow_locked) begin
            rd = PORT_IDLE;
          end else begin
            case (shadow_index)
              IDX_IDENT:   rd = host_regs.chip_ident;
              IDX_REV:     rd = host_regs.chip_revision;
              IDX_LDN:     rd = sio_ldn;
              IDX_ACTIVE:  rd = ACTIVE_ON;
              IDX_BASE_HI: rd = host_regs.uart_base_report[15:8];
              IDX_BASE_LO: rd = host_regs.uart_base_report[7:0];
              IDX_IRQ:     rd = {4'h0, host_regs.irq_number};
              default:     rd = 8'h00;
            endcase
          end
        end
        WIN_UART: begin
          case (it.reg_offset)
            OFF_RBR: begin
              if (dlab) begin
                rd = DLL_VALUE;
              end else if (reply_idx < reply_len) begin
                case (reply_idx)
                  2'd0:    rd = HS_ACK;
                  2'd1:    rd = host_regs.version_high;
                  default: rd = host_regs.version_low;
                endcase
                reply_idx = reply_idx + 2'd1;
                if (reply_idx >= reply_len) begin
                  uart_rx_ready = 1'b0;
                  irq_q = 1'b0;
                end
              end
            end
            OFF_IER: rd = dlab ? 8'h00 : shadow_ier;
            OFF_IIR: rd = uart_rx_ready ? IIR_RXAVAIL : IIR_NONE;
            OFF_LCR: rd = shadow_lcr;
            OFF_MCR: rd = shadow_mcr;
            OFF_LSR: rd = LSR_TXEMPTY | {7'h00, uart_rx_ready};
            default: rd = 8'h00;
          endcase
        end
        default: rd = PORT_IDLE;
      endcase
    end
    res.read_data = rd;
    res.irq_line = irq_q;
  endtask

  // Request driver: an item stays on the channel until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    suhd_result_t res;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_access(drv_item, res);
        predicted_reads.push_back(res);
        sent_items++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (!hold_tx && pending_accesses.size() != 0 &&
            !(gaps_en && $urandom_range(99) < 23)) begin
          drv_item = pending_accesses.pop_front();
          req_if.valid      <= 1'b1;
          req_if.req_type   <= drv_item.req_type;
          req_if.window     <= drv_item.window;
          req_if.reg_offset <= drv_item.reg_offset;
          req_if.write_data <= drv_item.write_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    suhd_result_t exp_res;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        checked_results++;
        if (rsp_if.irq_line) irq_results++;
        if (predicted_reads.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: response with nothing pending: read_data=%02h irq_line=%0b",
                     rsp_if.read_data, rsp_if.irq_line);
        end else begin
          exp_res = predicted_reads.pop_front();
          if (rsp_if.read_data !== exp_res.read_data || rsp_if.irq_line !== exp_res.irq_line)
          begin
            fail_count++;
            if (fail_count <= 10)
              $display("ERROR: result %0d: read_data exp %02h got %02h, irq_line exp %0b got %0b",
                       checked_results, exp_res.read_data, rsp_if.read_data,
                       exp_res.irq_line, rsp_if.irq_line);
          end
        end
      end
      rsp_if.ready <= !(gaps_en && $urandom_range(99) < 23);
    end
  end

  task automatic push_access(input logic rw, input logic [1:0] win, input logic [2:0] off,
                             input logic [7:0] data);
    suhd_item_t it;
    it.req_type = rw;
    it.window = win;
    it.reg_offset = off;
    it.write_data = data;
    pending_accesses.push_back(it);
    queued_items++;
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input suhd_cfg_t c);
    apb_write(CFG_CHIP_IDENT, 32'(c.chip_ident));
    apb_write(CFG_CHIP_REVISION, 32'(c.chip_revision));
    apb_write(CFG_UART_BASE, 32'(c.uart_base_report));
    apb_write(CFG_IRQ_NUMBER, 32'(c.irq_number));
    apb_write(CFG_VERSION_HIGH, 32'(c.version_high));
    apb_write(CFG_VERSION_LOW, 32'(c.version_low));
    host_regs = c;
    settings_loaded++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_accesses.size() != 0 || req_if.valid || predicted_reads.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_cfg_index();
    case ($urandom_range(7))
      0:       return IDX_IDENT;
      1:       return IDX_REV;
      2:       return IDX_LDN;
      3:       return IDX_ACTIVE;
      4:       return IDX_BASE_HI;
      5:       return IDX_BASE_LO;
      6:       return IDX_IRQ;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed unlock and handshake sequences, the rest noise.
  task automatic queue_sequence();
    int unsigned pick;
    int unsigned n;
    logic [2:0]  off;
    pick = $urandom_range(99);
    if (pick < 30) begin
      push_access(REQ_WRITE, WIN_INDEX, 3'($urandom_range(7)), KEY_UNLOCK);
      // A lone unlock key leaves the port locked.
      if ($urandom_range(9) != 0)
        push_access(REQ_WRITE, WIN_INDEX, 3'($urandom_range(7)), KEY_UNLOCK);
      push_access(REQ_WRITE, WIN_INDEX, 3'($urandom_range(7)), pick_cfg_index());
      n = $urandom_range(3, 1);
      repeat (n) begin
        if ($urandom_range(3) == 0)
          push_access(REQ_WRITE, WIN_DATA, 3'($urandom_range(7)), 8'($urandom_range(255)));
        else
          push_access(REQ_READ, WIN_DATA, 3'($urandom_range(7)), 8'($urandom_range(255)));
      end
      if ($urandom_range(9) < 4)
        push_access(REQ_WRITE, WIN_INDEX, 3'($urandom_range(7)), KEY_LOCK);
    end else if (pick < 65) begin
      if ($urandom_range(9) == 0)
        push_access(REQ_WRITE, WIN_UART, OFF_LCR, 8'($urandom_range(255)));
      else
        push_access(REQ_WRITE, WIN_UART, OFF_LCR, 8'($urandom_range(127)));
      if ($urandom_range(9) < 7)
        push_access(REQ_WRITE, WIN_UART, OFF_IER, 8'($urandom_range(255)));
      if ($urandom_range(9) != 0)
        push_access(REQ_WRITE, WIN_UART, OFF_RBR, HS_REQUEST);
      else
        push_access(REQ_WRITE, WIN_UART, OFF_RBR, 8'($urandom_range(255)));
      n = $urandom_range(5, 2);
      repeat (n) begin
        case ($urandom_range(5))
          0:       off = OFF_IIR;
          1:       off = OFF_LSR;
          2:       off = OFF_IER;
          default: off = OFF_RBR;
        endcase
        push_access(REQ_READ, WIN_UART, off, 8'($urandom_range(255)));
      end
    end else if (pick < 85) begin
      push_access(1'($urandom_range(1)), WIN_UART, 3'($urandom_range(7)),
                  8'($urandom_range(255)));
    end else begin
      push_access(1'($urandom_range(1)), 2'($urandom_range(3)), 3'($urandom_range(7)),
                  8'($urandom_range(255)));
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    stop_at = queued_items + n;
    while (queued_items < stop_at) queue_sequence();
  endtask

  initial begin
    suhd_cfg_t c;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_READ;
    req_if.window     = WIN_INDEX;
    req_if.reg_offset = OFF_RBR;
    req_if.write_data = 8'h00;
    rsp_if.ready      = 1'b0;
    host_regs.chip_ident       = RST_CHIP_IDENT;
    host_regs.chip_revision    = RST_CHIP_REVISION;
    host_regs.uart_base_report = RST_UART_BASE;
    host_regs.irq_number       = RST_IRQ_NUMBER;
    host_regs.version_high     = RST_VERSION_HIGH;
    host_regs.version_low      = RST_VERSION_LOW;
    shadow_index   = 8'h00;
    sio_ldn        = 8'h00;
    shadow_locked  = 1'b1;
    sio_unlock_cnt = 2'd0;
    shadow_lcr     = 8'h00;
    shadow_ier     = 8'h00;
    shadow_mcr     = 8'h00;
    uart_rx_ready  = 1'b0;
    reply_idx      = 2'd0;
    reply_len      = 2'd0;
    irq_q          = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on the reset settings.
    push_access(REQ_READ,  WIN_INDEX, OFF_RBR, 8'h00);
    push_access(REQ_READ,  WIN_DATA,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, KEY_UNLOCK);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, KEY_UNLOCK);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, IDX_IDENT);
    push_access(REQ_READ,  WIN_DATA,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, IDX_LDN);
    push_access(REQ_WRITE, WIN_DATA,  OFF_RBR, 8'hFF);
    push_access(REQ_READ,  WIN_DATA,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, IDX_BASE_HI);
    push_access(REQ_READ,  WIN_DATA,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_INDEX, OFF_RBR, KEY_LOCK);
    push_access(REQ_READ,  WIN_DATA,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_UART,  OFF_IER, IER_RXINT);
    push_access(REQ_WRITE, WIN_UART,  OFF_RBR, HS_REQUEST);
    push_access(REQ_READ,  WIN_UART,  OFF_IIR, 8'h00);
    push_access(REQ_READ,  WIN_UART,  OFF_LSR, 8'h00);
    push_access(REQ_READ,  WIN_UART,  OFF_RBR, 8'h00);
    push_access(REQ_READ,  WIN_UART,  OFF_RBR, 8'h00);
    push_access(REQ_READ,  WIN_UART,  OFF_RBR, 8'h00);
    push_access(REQ_READ,  WIN_UART,  OFF_RBR, 8'h00);
    push_access(REQ_WRITE, WIN_UART,  OFF_LCR, DLAB_MASK);
    push_access(REQ_READ,  WIN_UART,  OFF_RBR, 8'h00);
    push_access(REQ_READ,  WIN_NONE,  3'd7,    8'h00);
    push_access(REQ_WRITE, WIN_NONE,  3'd7,    8'hFF);
    wait_idle();

    c = '0;
    load_settings(c);
    run_random(120);
    wait_idle();

    // All-ones settings, with both channels running without gaps.
    c = '1;
    load_settings(c);
    gaps_en = 1'b0;
    run_random(120);
    wait_idle();
    gaps_en = 1'b1;

    c.chip_ident       = 8'($urandom_range(255));
    c.chip_revision    = 8'($urandom_range(255));
    c.uart_base_report = 16'($urandom_range(65535));
    c.irq_number       = 4'($urandom_range(15));
    c.version_high     = 8'($urandom_range(255));
    c.version_low      = 8'($urandom_range(255));
    load_settings(c);
    run_random(130);
    // Hold the sender back until the response side has caught up.
    while (pending_accesses.size() > 65) @(negedge clk_i);
    hold_tx = 1'b1;
    do @(negedge clk_i); while (req_if.valid || predicted_reads.size() != 0);
    repeat ($urandom_range(8, 2)) @(negedge clk_i);
    hold_tx = 1'b0;
    wait_idle();

    c.chip_ident       = 8'($urandom_range(255));
    c.chip_revision    = 8'($urandom_range(255));
    c.uart_base_report = 16'($urandom_range(65535));
    c.irq_number       = 4'($urandom_range(15));
    c.version_high     = 8'($urandom_range(255));
    c.version_low      = 8'($urandom_range(255));
    load_settings(c);
    run_random(130);
    wait_idle();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d accesses under %0d host register settings.",
             sent_items, settings_loaded);
    $display("Checked %0d results, %0d with the interrupt line high, %0d failures.",
             checked_results, irq_results, fail_count);
    if (fail_count == 0 && predicted_reads.size() == 0) begin
      $display("superio_uart_handshake_device_test: PASS");
    end else begin
      $display("superio_uart_handshake_device_test: FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout with %0d results outstanding.", predicted_reads.size());
    $display("superio_uart_handshake_device_test: FAIL");
    $finish;
  end

endmodule
